// File: rtl/core/ssc_pkg.sv
// Shared types, constants and tables of the swerve steering controller.
package ssc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_BASE_X = 3'd0;
	localparam logic [2:0] REG_BASE_Y = 3'd1;
	localparam logic [2:0] REG_ENC_OFFSET = 3'd2;
	localparam logic [2:0] REG_DEADBAND = 3'd3;
	localparam logic [2:0] REG_MIN_TURN = 3'd4;
	localparam logic [2:0] REG_LOCKOUT = 3'd5;

	// Operation codes.
	localparam logic OP_VECTOR = 1'b0;
	localparam logic OP_STEER = 1'b1;

	localparam int TABLE_LEN = 24;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQR,
		ST_SQRT,
		ST_CORDIC,
		ST_STEER,
		ST_OUT
	} ssc_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic vec_form;
		logic sq_form;
		logic sqrt_init;
		logic sqrt_step;
		logic cor_init;
		logic cor_step;
		logic steer;
		logic mag_load;
	} ssc_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic sqrt_done;
		logic cor_done;
	} ssc_stat_t;

	// Arctangent of 2^-i in 2^-32 turns.
	function automatic logic [31:0] atan_lookup(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10680862;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/swerve_steering_controller_core.sv
// Top level of the swerve steering controller.
//  channel  | valid     | stall     | payload
//  input    | in_valid  | in_stall  | operation .. now_ticks
//  output   | out_valid | out_stall | magnitude, turn_cmd, drive_cmd
//  config   | cfg_write | -         | cfg_index, cfg_data
// A vector request, once taken, goes through multiply, square,
// 19 root steps, a check that the root is done, and the output state.
// A steer request goes through setup, the rotations, a check that they are
// done, the steering law and the output state.
// One request is in work at a time; in_stall is high until the result is taken,
// and the next request is taken in the idle state after that.
// Reset clears the stored vector, the lockout and loads the register defaults.
module swerve_steering_controller_core import ssc_pkg::*; #(
	parameter int ADC_BITS = 12,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic signed [15:0] translate_x,
	input  logic signed [15:0] translate_y,
	input  logic signed [15:0] rotate_rate,
	input  logic [14:0] drive_magnitude,
	input  logic [ADC_BITS-1:0] encoder_sample,
	input  logic [31:0] now_ticks,
	output logic out_valid,
	input  logic out_stall,
	output logic [17:0] magnitude,
	output logic signed [15:0] turn_cmd,
	output logic [14:0] drive_cmd,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	ssc_cmd_t cmd;
	ssc_stat_t stat;

	ssc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .op(operation),
		.out_stall(out_stall), .stat(stat), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	ssc_dpath #(.ADC_BITS(ADC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.translate_x(translate_x), .translate_y(translate_y),
		.rotate_rate(rotate_rate), .drive_magnitude(drive_magnitude),
		.encoder_sample(encoder_sample), .now_ticks(now_ticks),
		.magnitude(magnitude), .turn_cmd(turn_cmd), .drive_cmd(drive_cmd)
	);

`ifndef ASSERT_OFF
	// No new request is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while result pending");
	// A taken result is followed by readiness for the next request.
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !in_stall) else $error("not ready after result");
	// An accepted request never yields a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid) else $error("result too early");
`endif

endmodule

// File: rtl/core/ssc_ctrl.sv
// Controller state machine of the swerve steering controller.
module ssc_ctrl import ssc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic op,
	input  logic out_stall,
	input  ssc_stat_t stat,
	output logic in_stall,
	output logic out_valid,
	output ssc_cmd_t cmd
);

	ssc_state_t state_q, state_d;
	logic op_q;

	// State register and latched operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_VECTOR;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) op_q <= op;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (op_q == OP_VECTOR) begin
					cmd.vec_form = 1'b1;
					state_d = ST_SQR;
				end else begin
					cmd.cor_init = 1'b1;
					state_d = ST_CORDIC;
				end
			end
			ST_SQR: begin
				cmd.sq_form = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (stat.sqrt_done) begin
					cmd.mag_load = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			ST_CORDIC: begin
				if (stat.cor_done) state_d = ST_STEER;
				else cmd.cor_step = 1'b1;
			end
			ST_STEER: begin
				cmd.steer = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.sqrt_init = cmd.sq_form;
	end

endmodule

// File: rtl/core/ssc_dpath.sv
// Datapath of the swerve steering controller: vector, root, CORDIC and steering.
module ssc_dpath import ssc_pkg::*; #(
	parameter int ADC_BITS = 12,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  ssc_cmd_t cmd,
	output ssc_stat_t stat,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic signed [15:0] translate_x,
	input  logic signed [15:0] translate_y,
	input  logic signed [15:0] rotate_rate,
	input  logic [14:0] drive_magnitude,
	input  logic [ADC_BITS-1:0] encoder_sample,
	input  logic [31:0] now_ticks,
	output logic [17:0] magnitude,
	output logic signed [15:0] turn_cmd,
	output logic [14:0] drive_cmd
);

	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int CW = 34;

	// Configuration registers.
	logic signed [15:0] base_x_q, base_y_q;
	logic [ADC_BITS-1:0] enc_off_q;
	logic [14:0] deadband_q, min_turn_q;
	logic [15:0] lockout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= 16'sd16384;
			base_y_q <= 16'sd16384;
			enc_off_q <= ADC_BITS'(2236);
			deadband_q <= 15'd728;
			min_turn_q <= 15'd8192;
			lockout_q <= 16'd100;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASE_X: base_x_q <= cfg_data;
				REG_BASE_Y: base_y_q <= cfg_data;
				REG_ENC_OFFSET: enc_off_q <= cfg_data[ADC_BITS-1:0];
				REG_DEADBAND: deadband_q <= cfg_data[14:0];
				REG_MIN_TURN: min_turn_q <= cfg_data[14:0];
				REG_LOCKOUT: lockout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input item registers.
	logic signed [15:0] tx_q, ty_q, rr_q;
	logic [14:0] drive_q;
	logic [ADC_BITS-1:0] sample_q;
	logic [31:0] now_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q <= translate_x;
			ty_q <= translate_y;
			rr_q <= rotate_rate;
			drive_q <= drive_magnitude;
			sample_q <= encoder_sample;
			now_q <= now_ticks;
		end
	end

	// Wheel vector: arithmetic shift floors the product.
	logic signed [31:0] px, py;
	logic signed [17:0] vec_x_q, vec_y_q;
	assign px = base_x_q * rr_q;
	assign py = base_y_q * rr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_x_q <= '0;
			vec_y_q <= '0;
		end else if (cmd.vec_form) begin
			vec_x_q <= 18'(px >>> 14) + 18'(tx_q);
			vec_y_q <= 18'(py >>> 14) + 18'(ty_q);
		end
	end

	// Sum of squares, registered after the multipliers.
	logic [35:0] sqx, sqy;
	logic [36:0] sq_sum;
	assign sqx = 36'($signed(vec_x_q) * $signed(vec_x_q));
	assign sqy = 36'($signed(vec_y_q) * $signed(vec_y_q));
	assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

	// Integer square root, one result bit per cycle.
	logic [18:0] root_q;
	logic [4:0] sq_cnt_q;
	logic [20:0] trial;
	logic [37:0] rad_q;
	logic [21:0] acc_q;
	logic [21:0] acc_next;
	logic ge;
	assign trial = {root_q, 2'b01};
	assign acc_next = {acc_q[19:0], rad_q[37:36]};
	assign ge = acc_next >= 22'(trial);
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rad_q <= {1'b0, sq_sum};
			acc_q <= '0;
			root_q <= '0;
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[35:0], 2'b00};
			acc_q <= ge ? acc_next - 22'(trial) : acc_next;
			root_q <= {root_q[17:0], ge};
			sq_cnt_q <= sq_cnt_q + 5'd1;
		end
	end
	assign stat.sqrt_done = (sq_cnt_q == 5'd19);

	// CORDIC vectoring, one rotation per cycle.
	logic signed [CW-1:0] cx_q, cy_q;
	logic [31:0] ang_q;
	logic [4:0] ci_q;
	logic signed [CW-1:0] ix, iy;
	logic zero_vec;
	assign zero_vec = (vec_x_q == 18'sd0) && (vec_y_q == 18'sd0);
	assign ix = CW'(vec_x_q) <<< 12;
	assign iy = CW'(vec_y_q) <<< 12;
	always_ff @(posedge clk) begin
		if (cmd.cor_init) begin
			ci_q <= '0;
			if (vec_x_q < 0) begin
				cx_q <= -ix;
				cy_q <= -iy;
				ang_q <= 32'h8000_0000;
			end else begin
				cx_q <= ix;
				cy_q <= iy;
				ang_q <= '0;
			end
		end else if (cmd.cor_step) begin
			ci_q <= ci_q + 5'd1;
			if (cy_q > 0) begin
				cx_q <= cx_q + (cy_q >>> ci_q);
				cy_q <= cy_q - (cx_q >>> ci_q);
				ang_q <= ang_q + atan_lookup(ci_q);
			end else begin
				cx_q <= cx_q - (cy_q >>> ci_q);
				cy_q <= cy_q + (cx_q >>> ci_q);
				ang_q <= ang_q - atan_lookup(ci_q);
			end
		end
	end
	assign stat.cor_done = (ci_q == 5'(STEPS));

	// Steering law.
	logic [31:0] ang_r;
	logic [15:0] target, cur, du;
	logic [ADC_BITS-1:0] ediff;
	logic signed [17:0] tv0, tv1, tv2, tv;
	logic [15:0] adiff;
	logic signed [15:0] prev_q;
	logic locked_q;
	logic [31:0] rel_q;
	logic set_lock, lk;
	logic [31:0] rel, dt;
	logic signed [17:0] mt;
	assign ang_r = ang_q + 32'h8000;
	assign target = zero_vec ? 16'd0 : ang_r[31:16];
	assign ediff = enc_off_q - sample_q;
	assign cur = 16'(ediff) << (16 - ADC_BITS);
	assign du = target - cur;
	assign mt = 18'(min_turn_q);
	always_comb begin
		tv0 = 18'($signed(du)) <<< 1;
		adiff = du[15] ? 16'(-du) : du;
		if (tv0 > 18'sd32767) tv1 = 18'sd32767;
		else if (tv0 < -18'sd32767) tv1 = -18'sd32767;
		else tv1 = tv0;
		if (tv1 > 0 && tv1 < mt) tv2 = mt;
		else if (tv1 < 0 && tv1 > -mt) tv2 = -mt;
		else tv2 = tv1;
		if (adiff < 16'(deadband_q)) tv = '0;
		else tv = tv2;
		set_lock = ((tv > 0 && prev_q < 0) || (tv < 0 && prev_q > 0)) && !locked_q;
		lk = locked_q || set_lock;
		rel = set_lock ? now_q + 32'(lockout_q) : rel_q;
		dt = now_q - rel;
	end

	// Lockout state and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			locked_q <= 1'b0;
			rel_q <= '0;
		end else if (cmd.steer) begin
			rel_q <= rel;
			locked_q <= lk && !(dt != 32'd0 && !dt[31]);
			prev_q <= lk ? 16'sd0 : 16'(tv);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_form) begin
			turn_cmd <= '0;
			drive_cmd <= '0;
		end
		if (cmd.mag_load) begin
			magnitude <= root_q[17:0];
		end
		if (cmd.steer) begin
			magnitude <= '0;
			turn_cmd <= (lk || zero_vec) ? 16'sd0 : -16'(tv);
			drive_cmd <= zero_vec ? 15'd0 : drive_q;
		end
	end

endmodule
